@@ hw/rtl/esc_pkg.sv @@
package esc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_TEMP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRES_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRES_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIXED     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM       = 3'd4;

  localparam int signed TEMP_MIN    = -4000;
  localparam int signed TEMP_MAX    = 8500;
  localparam logic [31:0] PRES_MIN  = 32'd3000000;
  localparam logic [31:0] PRES_MAX  = 32'd11000000;
  localparam logic [16:0] HUM_MAX   = 17'd102400;
  localparam int signed HUM_RAW_MAX = 419430400;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_pres;
    logic [15:0] raw_hum;
  } in_word_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [23:0]        pres_centi_pa;
    logic [16:0]        hum_q10;
  } out_word_t;

  // Results that ride along with the divider
  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        hum;
    logic               zero;
  } div_side_t;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
                                                input int unsigned k);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [63:0] sdiv64(input logic signed [63:0] x,
                                                input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

@@ hw/rtl/env_sensor_compensation_unit.sv @@
// Pipeline from an accepted input word to its result word: 12 front stages,
// 66 in the divider, 3 pressure stages and 1 output register.
// Throughput: one word per cycle; the 64-stage divider is fully pipelined.
// Any stall on the result side holds the whole pipeline in place.
// Reset (synchronous, rst_n low) clears all valid bits and the coefficient
// registers to zero.
module env_sensor_compensation_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  esc_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output esc_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [63:0]                     cfg_data
);
  import esc_pkg::*;

  // ---------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------
  logic [47:0] temp_c_r;
  logic [63:0] pres_lo_r, pres_hi_r;
  logic [47:0] mixed_r;
  logic [31:0] hum_c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_c_r  <= '0;
      pres_lo_r <= '0;
      pres_hi_r <= '0;
      mixed_r   <= '0;
      hum_c_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP:      temp_c_r  <= cfg_data[47:0];
        REG_PRES_LOW:  pres_lo_r <= cfg_data;
        REG_PRES_HIGH: pres_hi_r <= cfg_data;
        REG_MIXED:     mixed_r   <= cfg_data[47:0];
        REG_HUM:       hum_c_r   <= cfg_data[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Coefficients, extended to their datapath width
  logic signed [31:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = $signed({16'd0, temp_c_r[15:0]});
  assign t2 = 32'(signed'(temp_c_r[31:16]));
  assign t3 = 32'(signed'(temp_c_r[47:32]));
  assign p1 = $signed({48'd0, pres_lo_r[15:0]});
  assign p2 = 64'(signed'(pres_lo_r[31:16]));
  assign p3 = 64'(signed'(pres_lo_r[47:32]));
  assign p4 = 64'(signed'(pres_lo_r[63:48]));
  assign p5 = 64'(signed'(pres_hi_r[15:0]));
  assign p6 = 64'(signed'(pres_hi_r[31:16]));
  assign p7 = 64'(signed'(pres_hi_r[47:32]));
  assign p8 = 64'(signed'(pres_hi_r[63:48]));
  assign p9 = 64'(signed'(mixed_r[15:0]));
  assign h1 = $signed({24'd0, mixed_r[23:16]});
  assign h2 = 32'(signed'(mixed_r[39:24]));
  assign h3 = $signed({24'd0, mixed_r[47:40]});
  assign h4 = 32'(signed'(hum_c_r[11:0]));
  assign h5 = 32'(signed'(hum_c_r[23:12]));
  assign h6 = 32'(signed'(hum_c_r[31:24]));

  // ---------------------------------------------------------------
  // Flow control: every stage advances together unless the output
  // register holds a word that is not taken.
  // ---------------------------------------------------------------
  logic en;
  logic out_valid_r;
  out_word_t out_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [12:1] v_r;

  // Stage registers (payload, no reset)
  logic [19:0] s1_rt, s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp, s8_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh, s5_rh, s6_rh;
  logic signed [31:0] s2_ma, s2_bb, s3_a, s3_mb, s4_tf, s5_d;
  logic signed [14:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic signed [14:0] s11_temp, s12_temp;
  logic signed [63:0] s5_pa, s6_paa, s6_pap5, s6_pap2, s7_m6, s7_m3, s7_pap5, s7_pap2;
  logic signed [63:0] s8_b, s8_a, s9_ma, s9_nb, s10_den, s10_num, s11_den, s11_num;
  logic signed [63:0] s12_den, s12_num;
  logic signed [31:0] s6_hz, s6_hx, s6_hy, s7_w, s7_hp, s8_w, s8_zh, s9_y;
  logic signed [31:0] s10_y, s10_sq, s11_y, s11_zh1;
  logic [16:0] s12_hum;
  logic        s12_zero;

  // Combinational helpers
  logic signed [31:0] ta, tb, tt, hx0, hw, s10_yq, wf;
  logic signed [63:0] c0;
  logic [16:0]        hum_nxt;

  always_comb begin
    ta     = $signed({15'd0, s1_rt[19:3]}) - (t1 <<< 1);
    tb     = $signed({16'd0, s1_rt[19:4]}) - t1;
    tt     = sdiv32(s4_tf * 32'sd5 + 32'sd128, 8);
    hx0    = $signed({2'd0, s6_rh, 14'd0});
    hw     = hx0 - (h4 <<< 20) - s6_hz + 32'sd16384;
    c0     = 64'sd1048576 - $signed({44'd0, s8_rp});
    s10_yq = sdiv32(s9_y, 15);
    wf     = s11_y - sdiv32(s11_zh1, 4);
    if (wf < 0) begin
      wf = 32'sd0;
    end else if (wf > HUM_RAW_MAX) begin
      wf = HUM_RAW_MAX;
    end
    hum_nxt = (wf[28:12] > HUM_MAX) ? HUM_MAX : wf[28:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[11:1], in_valid};
    end
    if (en) begin
      // stage 1: capture the raw word
      s1_rt <= in_data.raw_temp;
      s1_rp <= in_data.raw_pres;
      s1_rh <= in_data.raw_hum;
      // stage 2: temperature products
      s2_ma <= ta * t2;
      s2_bb <= tb * tb;
      s2_rp <= s1_rp;  s2_rh <= s1_rh;
      // stage 3
      s3_a  <= sdiv32(s2_ma, 11);
      s3_mb <= sdiv32(s2_bb, 12) * t3;
      s3_rp <= s2_rp;  s3_rh <= s2_rh;
      // stage 4: fine temperature
      s4_tf <= s3_a + sdiv32(s3_mb, 14);
      s4_rp <= s3_rp;  s4_rh <= s3_rh;
      // stage 5: clamp temperature, offsets for the other two paths
      if (tt < TEMP_MIN) begin
        s5_temp <= 15'(TEMP_MIN);
      end else if (tt > TEMP_MAX) begin
        s5_temp <= 15'(TEMP_MAX);
      end else begin
        s5_temp <= tt[14:0];
      end
      s5_pa <= 64'(s4_tf) - 64'sd128000;
      s5_d  <= s4_tf - 32'sd76800;
      s5_rp <= s4_rp;  s5_rh <= s4_rh;
      // stage 6: first products of both paths
      s6_paa  <= s5_pa * s5_pa;
      s6_pap5 <= s5_pa * p5;
      s6_pap2 <= s5_pa * p2;
      s6_hz   <= h5 * s5_d;
      s6_hx   <= s5_d * h6;
      s6_hy   <= s5_d * h3;
      s6_temp <= s5_temp;  s6_rp <= s5_rp;  s6_rh <= s5_rh;
      // stage 7
      s7_m6   <= s6_paa * p6;
      s7_m3   <= s6_paa * p3;
      s7_pap5 <= s6_pap5;
      s7_pap2 <= s6_pap2;
      s7_w    <= sdiv32(hw, 15);
      s7_hp   <= sdiv32(s6_hx, 10) * (sdiv32(s6_hy, 11) + 32'sd32768);
      s7_temp <= s6_temp;  s7_rp <= s6_rp;
      // stage 8: pressure offset and divisor sum
      s8_b    <= s7_m6 + (s7_pap5 <<< 17) + (p4 <<< 35);
      s8_a    <= sdiv64(s7_m3, 8) + (s7_pap2 <<< 12) + 64'sh0000_8000_0000_0000;
      s8_w    <= s7_w;
      s8_zh   <= (sdiv32(s7_hp, 10) + 32'sd2097152) * h2;
      s8_temp <= s7_temp;  s8_rp <= s7_rp;
      // stage 9
      s9_ma   <= s8_a * p1;
      s9_nb   <= (c0 <<< 31) - s8_b;
      s9_y    <= s8_w * sdiv32(s8_zh + 32'sd8192, 14);
      s9_temp <= s8_temp;
      // stage 10: divisor and dividend ready
      s10_den  <= sdiv64(s9_ma, 33);
      s10_num  <= s9_nb * 64'sd3125;
      s10_y    <= s9_y;
      s10_sq   <= s10_yq * s10_yq;
      s10_temp <= s9_temp;
      // stage 11
      s11_den  <= s10_den;
      s11_num  <= s10_num;
      s11_y    <= s10_y;
      s11_zh1  <= sdiv32(s10_sq, 7) * h1;
      s11_temp <= s10_temp;
      // stage 12: humidity done, flag a zero divisor
      s12_den  <= s11_den;
      s12_num  <= s11_num;
      s12_hum  <= hum_nxt;
      s12_zero <= (s11_den == 64'sd0);
      s12_temp <= s11_temp;
    end
  end

  // ---------------------------------------------------------------
  // Pressure division
  // ---------------------------------------------------------------
  div_side_t          dv_side_in, dv_side;
  logic               dv_v;
  logic signed [63:0] dv_q;

  assign dv_side_in = '{temp: s12_temp, hum: s12_hum, zero: s12_zero};

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_r[12]),
    .num      (s12_num),
    .den      (s12_den),
    .side_in  (dv_side_in),
    .out_v    (dv_v),
    .quo      (dv_q),
    .side_out (dv_side)
  );

  // ---------------------------------------------------------------
  // Pressure correction after the divide
  // ---------------------------------------------------------------
  logic [3:1]         pv_r;
  logic signed [63:0] p1_c, p1_q, p1_m8, p1_m9, p2_c, p2_m8, p2_mq, p3_c2;
  div_side_t          p1_side, p2_side, p3_side;
  logic signed [63:0] pv;
  logic [31:0]        pw;
  logic [23:0]        pres_nxt;
  logic [63:0]        mq_ll;
  logic [31:0]        mq_lh, mq_hl;

  // Low 64 bits of p1_m9 * p1_q from 32 x 32 partial products
  always_comb begin
    mq_ll = {32'd0, p1_m9[31:0]} * {32'd0, p1_q[31:0]};
    mq_lh = p1_m9[31:0] * p1_q[63:32];
    mq_hl = p1_m9[63:32] * p1_q[31:0];
  end

  always_comb begin
    pv = sdiv64(sdiv64(p3_c2, 1) * 64'sd100, 7);
    pw = pv[31:0];
    if (p3_side.zero || pw < PRES_MIN) begin
      pres_nxt = PRES_MIN[23:0];
    end else if (pw > PRES_MAX) begin
      pres_nxt = PRES_MAX[23:0];
    end else begin
      pres_nxt = pw[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= {pv_r[2:1], dv_v};
      out_valid_r <= pv_r[3];
    end
    if (en) begin
      p1_c    <= dv_q;
      p1_q    <= sdiv64(dv_q, 13);
      p1_m8   <= p8 * dv_q;
      p1_m9   <= p9 * sdiv64(dv_q, 13);
      p1_side <= dv_side;
      p2_c    <= p1_c;
      p2_m8   <= p1_m8;
      p2_mq   <= $signed(mq_ll + {mq_lh + mq_hl, 32'd0});
      p2_side <= p1_side;
      p3_c2   <= sdiv64(p2_c + sdiv64(p2_mq, 25) + sdiv64(p2_m8, 19), 8) + (p7 <<< 4);
      p3_side <= p2_side;
      // output register
      out_r.temp_centi    <= p3_side.temp;
      out_r.pres_centi_pa <= pres_nxt;
      out_r.hum_q10       <= p3_side.hum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

@@ hw/rtl/esc_div.sv @@
module esc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic signed [63:0]        num,
  input  logic signed [63:0]        den,
  input  esc_pkg::div_side_t        side_in,
  output logic                      out_v,
  output logic signed [63:0]        quo,
  output esc_pkg::div_side_t        side_out
);
  import esc_pkg::*;

  localparam int unsigned Steps = 64;

  logic [127:0]  acc_r  [0:Steps];
  logic [63:0]   dmag_r [0:Steps];
  logic          neg_r  [0:Steps];
  div_side_t     side_r [0:Steps];
  logic [Steps:0] v_r;
  logic          out_v_r;
  logic signed [63:0] quo_r;
  div_side_t     side_out_r;

  // load magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      acc_r[0]  <= {64'd0, (num[63] ? 64'(-num) : 64'(num))};
      dmag_r[0] <= den[63] ? 64'(-den) : 64'(den);
      neg_r[0]  <= num[63] ^ den[63];
      side_r[0] <= side_in;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [127:0] sh;
    logic [127:0] nx;
    always_comb begin
      sh = {acc_r[k-1][126:0], 1'b0};
      nx = sh;
      if (sh[127:64] >= dmag_r[k-1]) begin
        nx[127:64] = sh[127:64] - dmag_r[k-1];
        nx[0]      = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        acc_r[k]  <= nx;
        dmag_r[k] <= dmag_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[Steps];
    end
    if (en) begin
      quo_r      <= neg_r[Steps] ? $signed(-acc_r[Steps][63:0])
                                 : $signed(acc_r[Steps][63:0]);
      side_out_r <= side_r[Steps];
    end
  end

  assign out_v    = out_v_r;
  assign quo      = quo_r;
  assign side_out = side_out_r;
endmodule

@@ hw/rtl/esc_check.sv @@
module esc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input esc_pkg::out_word_t out_data
);
  import esc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.temp_centi >= -15'sd4000 && out_data.temp_centi <= 15'sd8500)
    else $error("temperature out of range");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pres_centi_pa >= 24'd3000000
                  && out_data.pres_centi_pa <= 24'd11000000)
    else $error("pressure out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hum_q10 <= HUM_MAX)
    else $error("humidity out of range");
endmodule

bind env_sensor_compensation_unit esc_check u_esc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ verif/tb_env_sensor_compensation_unit.sv @@
module tb_env_sensor_compensation_unit;
  import esc_pkg::*;

  // Settle past the pipeline depth before touching coefficients
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_TEMP;
  logic [63:0] cfg_data = '0;

  // Coefficient shadow, masked to register widths
  logic [63:0] coef [5];
  out_word_t expected_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  env_sensor_compensation_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Compute temperature, pressure and humidity for one raw word
  function automatic out_word_t compensate(in_word_t w);
    out_word_t res;
    int r, t1, t2, t3, a, b, tfine, t;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, pa, pb, pc, den, q;
    logic [31:0] pv;
    int h1, h2, h3, h4, h5, h6, d, x, y, z, hw;
    // Fine temperature
    t1 = int'(coef[0][15:0]);
    t2 = $signed(coef[0][31:16]);
    t3 = $signed(coef[0][47:32]);
    r = int'(w.raw_temp);
    a = (r / 8) - t1 * 2;
    a = (a * t2) / 2048;
    b = (r / 16) - t1;
    b = (b * b) / 4096;
    b = (b * t3) / 16384;
    tfine = a + b;
    t = (tfine * 5 + 128) / 256;
    if (t < TEMP_MIN) t = TEMP_MIN;
    else if (t > TEMP_MAX) t = TEMP_MAX;
    res.temp_centi = t[14:0];
    // Pressure, 64-bit path
    p1 = longint'(coef[1][15:0]);
    p2 = $signed(coef[1][31:16]);
    p3 = $signed(coef[1][47:32]);
    p4 = $signed(coef[1][63:48]);
    p5 = $signed(coef[2][15:0]);
    p6 = $signed(coef[2][31:16]);
    p7 = $signed(coef[2][47:32]);
    p8 = $signed(coef[2][63:48]);
    p9 = $signed(coef[3][15:0]);
    pa = longint'(tfine) - 64'sd128000;
    pb = pa * pa * p6;
    pb = pb + pa * p5 * 64'sd131072;
    pb = pb + p4 * 64'sd34359738368;
    den = (pa * pa * p3) / 256 + pa * p2 * 64'sd4096;
    den = ((64'sd140737488355328 + den) * p1) / 64'sd8589934592;
    if (den == 0) begin
      pv = PRES_MIN;
    end else begin
      pc = 64'sd1048576 - longint'(w.raw_pres);
      pc = (pc * 64'sd2147483648 - pb) * 64'sd3125;
      // Minus one divisor: wrapped negation, never a native overflow
      if (den == -64'sd1) pc = -pc;
      else pc = pc / den;
      q = pc / 8192;
      pa = (p9 * q * q) / 64'sd33554432;
      pb = (p8 * pc) / 64'sd524288;
      pc = (pc + pa + pb) / 256 + p7 * 16;
      pc = ((pc / 2) * 100) / 128;
      pv = pc[31:0];
      if (pv < PRES_MIN) pv = PRES_MIN;
      else if (pv > PRES_MAX) pv = PRES_MAX;
    end
    res.pres_centi_pa = pv[23:0];
    // Humidity, 32-bit path
    h1 = int'(coef[3][23:16]);
    h2 = $signed(coef[3][39:24]);
    h3 = int'(coef[3][47:40]);
    h4 = $signed(coef[4][11:0]);
    h5 = $signed(coef[4][23:12]);
    h6 = $signed(coef[4][31:24]);
    d = tfine - 76800;
    x = int'(w.raw_hum) * 16384;
    y = h4 * 1048576;
    z = h5 * d;
    hw = (x - y - z + 16384) / 32768;
    x = (d * h6) / 1024;
    y = (d * h3) / 2048;
    z = (x * (y + 32768)) / 1024 + 2097152;
    x = (z * h2 + 8192) / 16384;
    y = hw * x;
    z = ((y / 32768) * (y / 32768)) / 128;
    hw = y - (z * h1) / 16;
    if (hw < 0) hw = 0;
    if (hw > HUM_RAW_MAX) hw = HUM_RAW_MAX;
    hw = hw / 4096;
    if (hw > int'(HUM_MAX)) hw = int'(HUM_MAX);
    res.hum_q10 = hw[16:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    mismatches++;
  endtask

  // Send one word; valid stays high across back-to-back words
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(compensate(w));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP, REG_MIXED: coef[idx] = val & 64'hFFFF_FFFF_FFFF;
      REG_PRES_LOW, REG_PRES_HIGH: coef[idx] = val;
      REG_HUM: coef[idx] = val & 64'hFFFF_FFFF;
      default: ;
    endcase
  endtask

  // Drain the pipeline, then load all five coefficient registers
  task automatic load_coeffs(logic [63:0] c0, c1, c2, c3, c4);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    write_reg(REG_TEMP, c0);
    write_reg(REG_PRES_LOW, c1);
    write_reg(REG_PRES_HIGH, c2);
    write_reg(REG_MIXED, c3);
    write_reg(REG_HUM, c4);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] jit(int v, int j);
    int r;
    r = v + int'($urandom_range(2 * j)) - j;
    return r[15:0];
  endfunction

  // Calibration set near a real part's factory data, jittered by j
  task automatic load_typical(int j);
    logic [15:0] h4, h5;
    h4 = jit(313, j);
    h5 = jit(50, j);
    load_coeffs({jit(-1000, j), jit(26435, j), jit(27504, j)},
                {jit(2855, j), jit(3024, j), jit(-10685, j), jit(36477, j)},
                {jit(-14600, j), jit(15500, j), jit(-7, j), jit(140, j)},
                {jit(0, j / 8 + 1), jit(362, j), jit(75, j / 4 + 1), jit(6000, j)},
                {32'(jit(30, j / 8 + 1)) << 24 | 32'(h5[11:0]) << 12 | 32'(h4[11:0])});
  endtask

  function automatic in_word_t plausible_word();
    in_word_t w;
    w.raw_temp = 20'(519888 + int'($urandom_range(200000)) - 100000);
    w.raw_pres = 20'(415148 + int'($urandom_range(300000)) - 150000);
    w.raw_hum  = 16'(30000 + int'($urandom_range(40000)) - 20000);
    return w;
  endfunction

  function automatic in_word_t random_word();
    return in_word_t'({$urandom, $urandom});
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycles);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.temp_centi !== want.temp_centi)
          report_mismatch("temp_centi", out_data.temp_centi, want.temp_centi);
        if (out_data.pres_centi_pa !== want.pres_centi_pa)
          report_mismatch("pres_centi_pa", out_data.pres_centi_pa, want.pres_centi_pa);
        if (out_data.hum_q10 !== want.hum_q10)
          report_mismatch("hum_q10", out_data.hum_q10, want.hum_q10);
      end
    end
  end

  // Stall the result side at random while idling is enabled
  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at cycle %0d", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset coefficients are all zero: pressure divisor is zero
  task automatic test_reset_coeffs();
    send_word('0);
    send_word('1);
    send_word(plausible_word());
    send_word(random_word());
  endtask

  // Field extremes against a realistic calibration
  task automatic test_field_extremes();
    load_typical(0);
    send_word('0);
    send_word('1);
    send_word({20'hFFFFF, 20'h0, 16'hFFFF});
    send_word({20'h0, 20'hFFFFF, 16'h0});
    send_word({20'd519888, 20'd415148, 16'd30000});
    send_word({20'd519888, 20'd0, 16'hFFFF});
    for (int i = 0; i < 4; i++) send_word(plausible_word());
  endtask

  // t1 = 28772, t2 = 32767 give t_fine = -920675; with p1 = 1, p2 = 32767
  // the pressure divisor comes out at exactly minus one
  task automatic test_divisor_minus_one();
    load_coeffs({16'h0, 16'h7FFF, 16'd28772}, {16'h0, 16'h0, 16'h7FFF, 16'd1},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    send_word({20'h0, 20'h0, 16'h0});
    send_word({20'h0, 20'hFFFFF, 16'hFFFF});
    send_word({20'h7, 20'd415148, 16'd30000});
  endtask

  // All-ones and sign-bit coefficients; unmapped indexes must be ignored
  task automatic test_coeff_extremes();
    load_coeffs('1, '1, '1, '1, '1);
    write_reg(RegUnmapped, '0);
    write_reg(RegUnmapped + 3'd1, '0);
    write_reg(RegUnmapped + 3'd2, '0);
    cfg_valid <= 1'b0;
    send_word('0);
    send_word('1);
    send_word(plausible_word());
    load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h8000}},
                64'h80_8000_FF_8000, 64'h80_800_800);
    send_word('0);
    send_word('1);
    send_word(random_word());
  endtask

  // Phases of random words under varied calibration
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: load_typical(50);
        1: load_typical(2000);
        2: load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
        default: load_typical(300);
      endcase
      // Run one phase with no idling on either side
      idle_on = (ph != 5);
      for (int i = 0; i < 85; i++) begin
        // Hold off midway until the pipeline empties
        if (ph == 3 && i == 40) begin
          in_valid <= 1'b0;
          wait (expected_q.size() == 0);
          @(posedge clk);
        end
        send_word(($urandom_range(99) < 75) ? plausible_word() : random_word());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 5; i++) coef[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_coeffs();
    test_field_extremes();
    test_divisor_minus_one();
    test_coeff_extremes();
    test_random_phases();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
